FILE: sv/assert_macros.svh
// concurrent assertion helpers, sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLIES(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: sv/pe_utf8_pkg.sv
package pe_utf8_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       last_out;
		logic       string_done;
	} out_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_RAW  = 2'd1,
		OP_ESC  = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind0;
		logic [7:0] byte0;
		op_kind_t   kind1;
		logic [7:0] byte1;
		logic       eos;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_HEX_ALPHA = 8'h37;
	localparam logic [3:0] HEX_TEN = 4'd10;

	function automatic logic must_escape(logic [7:0] b, logic at_start);
		logic esc;
		esc = (b == CH_SPACE) || (b == CH_BSLASH) || (b == CH_STAR) ||
			(b == CH_QUEST) || (b == CH_PCT) || (b < CH_SPACE) || (b > CH_TILDE);
		if (b == CH_DOT && at_start) begin
			esc = 1'b1;
		end
		return esc;
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		logic [7:0] d;
		if (n < HEX_TEN) begin
			d = CH_ZERO + {4'h0, n};
		end else begin
			d = CH_HEX_ALPHA + {4'h0, n};
		end
		return d;
	endfunction

	// continuation bytes still allowed after the first one
	function automatic logic [1:0] cont_after_first(logic [7:0] lead);
		logic [1:0] c;
		if (lead[7:4] == 4'hF) begin
			c = 2'd2;
		end else if (lead[7:5] == 3'h7) begin
			c = 2'd1;
		end else begin
			c = 2'd0;
		end
		return c;
	endfunction

endpackage

FILE: sv/pe_utf8_front.sv
`include "assert_macros.svh"

module pe_utf8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pe_utf8_pkg::in_t  item,
	input  logic              q_full,
	output pe_utf8_pkg::q_wr_t q_wr
);

	logic       held_q;
	logic [7:0] held_byte_q;
	logic [1:0] cont_q;
	logic       start_q;

	logic       accept;
	logic [7:0] b;
	logic       eos;
	logic       is_lead;
	logic       fresh_hold;
	pe_utf8_pkg::op_kind_t fresh_kind;

	logic       held_d;
	logic [7:0] held_byte_d;
	logic [1:0] cont_d;
	pe_utf8_pkg::cmd_t cmd;

	assign accept = push && !q_full;
	assign b = item.byte_in;
	assign eos = item.end_of_string;
	assign is_lead = (b[7:6] == 2'b11);
	assign fresh_hold = is_lead && !eos;
	assign fresh_kind = pe_utf8_pkg::must_escape(b, start_q) ?
		pe_utf8_pkg::OP_ESC : pe_utf8_pkg::OP_RAW;

	always_comb begin
		held_d = 1'b0;
		held_byte_d = 8'h00;
		cont_d = 2'd0;
		cmd.kind0 = pe_utf8_pkg::OP_NONE;
		cmd.byte0 = b;
		cmd.kind1 = pe_utf8_pkg::OP_NONE;
		cmd.byte1 = b;
		cmd.eos = eos;
		priority if (held_q) begin
			cmd.byte0 = held_byte_q;
			if (b[7]) begin
				cmd.kind0 = pe_utf8_pkg::OP_RAW;
				cmd.kind1 = pe_utf8_pkg::OP_RAW;
				cont_d = pe_utf8_pkg::cont_after_first(held_byte_q);
			end else begin
				// lone lead, new byte handled as fresh (it cannot be a lead)
				cmd.kind0 = pe_utf8_pkg::OP_ESC;
				cmd.kind1 = fresh_kind;
			end
		end else if (cont_q != 2'd0 && b[7]) begin
			cmd.kind0 = pe_utf8_pkg::OP_RAW;
			cont_d = cont_q - 2'd1;
		end else if (fresh_hold) begin
			held_d = 1'b1;
			held_byte_d = b;
		end else begin
			cmd.kind0 = fresh_kind;
		end
		if (eos) begin
			held_d = 1'b0;
			held_byte_d = 8'h00;
			cont_d = 2'd0;
		end
	end

	assign q_wr.push = accept && (cmd.kind0 != pe_utf8_pkg::OP_NONE);
	assign q_wr.cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			held_byte_q <= 8'h00;
			cont_q <= 2'd0;
			start_q <= 1'b1;
		end else if (accept) begin
			held_q <= held_d;
			held_byte_q <= held_byte_d;
			cont_q <= cont_d;
			start_q <= eos;
		end
	end

	`CHK_IMPLIES(a_held_no_cont, held_q, cont_q == 2'd0, "lead held with continuations pending")
	`CHK_IMPLIES(a_held_is_lead, held_q, held_byte_q[7:6] == 2'b11, "held byte is not a lead")

endmodule

FILE: sv/pe_utf8_queue.sv
`include "assert_macros.svh"

module pe_utf8_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  pe_utf8_pkg::q_wr_t q_wr,
	output logic               full,
	output pe_utf8_pkg::cmd_t  head,
	output logic               head_valid,
	input  logic               head_pop
);

	pe_utf8_pkg::cmd_t head_q;
	pe_utf8_pkg::cmd_t tail_q;
	logic              head_v_q;
	logic              tail_v_q;

	assign full = tail_v_q;
	assign head = head_q;
	assign head_valid = head_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else begin
			if (head_pop) begin
				if (tail_v_q) begin
					tail_v_q <= q_wr.push;
				end else begin
					head_v_q <= q_wr.push;
				end
			end else if (q_wr.push) begin
				if (head_v_q) begin
					tail_v_q <= 1'b1;
				end else begin
					head_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			if (tail_v_q) begin
				head_q <= tail_q;
				tail_q <= q_wr.cmd;
			end else begin
				head_q <= q_wr.cmd;
			end
		end else if (q_wr.push) begin
			if (head_v_q) begin
				tail_q <= q_wr.cmd;
			end else begin
				head_q <= q_wr.cmd;
			end
		end
	end

	`CHK_IMPLIES(a_tail_needs_head, tail_v_q, head_v_q, "queue tail valid without head")
	`CHK_NEVER(a_pop_empty, head_pop && !head_v_q, "pop from empty queue")

endmodule

FILE: sv/pe_utf8_back.sv
`include "assert_macros.svh"

module pe_utf8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pe_utf8_pkg::cmd_t head,
	input  logic              head_valid,
	output logic              head_pop,
	output pe_utf8_pkg::out_t result,
	output logic              empty,
	input  logic              pop
);

	logic              sel_q;
	logic [1:0]        ph_q;
	logic              out_v_q;
	pe_utf8_pkg::out_t out_q;

	pe_utf8_pkg::op_kind_t kind;
	logic [7:0]        cur_byte;
	logic [7:0]        emit;
	logic              op_last;
	logic              cmd_last;
	logic              advance;

	assign kind = sel_q ? head.kind1 : head.kind0;
	assign cur_byte = sel_q ? head.byte1 : head.byte0;

	always_comb begin
		emit = cur_byte;
		op_last = 1'b1;
		unique case (kind)
			pe_utf8_pkg::OP_ESC: begin
				op_last = (ph_q == 2'd2);
				unique case (ph_q)
					2'd0: emit = pe_utf8_pkg::CH_PCT;
					2'd1: emit = pe_utf8_pkg::hex_digit(cur_byte[7:4]);
					2'd2: emit = pe_utf8_pkg::hex_digit(cur_byte[3:0]);
					default: emit = cur_byte;
				endcase
			end
			pe_utf8_pkg::OP_RAW: begin
				emit = cur_byte;
			end
			default: begin
				emit = cur_byte;
			end
		endcase
	end

	assign cmd_last = op_last && (sel_q || head.kind1 == pe_utf8_pkg::OP_NONE);
	assign advance = head_valid && (!out_v_q || pop);
	assign head_pop = advance && cmd_last;

	assign result = out_q;
	assign empty = !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			ph_q <= 2'd0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
			if (cmd_last) begin
				sel_q <= 1'b0;
				ph_q <= 2'd0;
			end else if (op_last) begin
				sel_q <= 1'b1;
				ph_q <= 2'd0;
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.byte_out <= emit;
			out_q.last_out <= cmd_last;
			out_q.string_done <= cmd_last && head.eos;
		end
	end

	`CHK_IMPLIES(a_phase_on_escape, head_valid && ph_q != 2'd0,
		kind == pe_utf8_pkg::OP_ESC && ph_q != 2'd3, "digit phase outside an escape")
	`CHK_IMPLIES(a_second_op_real, head_valid && sel_q,
		head.kind1 != pe_utf8_pkg::OP_NONE, "second op selected but absent")

endmodule

FILE: sv/percent_escape_utf8_bytes_top.sv
// Percent-escaper for name strings, UTF-8 aware. One raw byte enters per push beat and
// each output byte leaves as its own pop beat; last_out marks the final byte caused by an
// input beat and string_done the final byte of a string. A UTF-8 lead byte is held until the
// next byte arrives, so a beat that only holds a lead gives no output. The front end builds a
// command combinationally and hands it to a two-entry queue; the back end then emits one byte
// per cycle through its output register while its output is popped: one output byte for a
// byte that passes unchanged, three for an escaped byte, up to six for a lone lead followed
// by an escaped byte. Input is taken every cycle while the queue has room, so sustained rate
// is set by the back end's one output byte per cycle.

module percent_escape_utf8_bytes_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pe_utf8_pkg::in_t  item,
	output logic              empty,
	input  logic              pop,
	output pe_utf8_pkg::out_t result
);

	pe_utf8_pkg::q_wr_t q_wr;
	pe_utf8_pkg::cmd_t  head;
	logic               head_valid;
	logic               head_pop;

	pe_utf8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (full),
		.q_wr   (q_wr)
	);

	pe_utf8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_wr       (q_wr),
		.full       (full),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	pe_utf8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_BEATS = 480;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	pe_utf8_pkg::in_t item = '0;
	pe_utf8_pkg::out_t result;

	percent_escape_utf8_bytes_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pe_utf8_pkg::in_t raw_bytes_q[$];
	pe_utf8_pkg::out_t escaped_q[$];
	logic [7:0] beat_bytes[$];

	// escaper state
	logic lead_wait = 1'b0;
	logic [7:0] lead_byte = '0;
	logic [1:0] cont_left = '0;
	logic str_start = 1'b1;

	int err_cnt = 0;
	int idle_cnt = 0;
	int push_gap = 0;
	int pop_gap = 0;
	int push_calm = 0;
	int pop_calm = 0;

	task automatic report_mismatch(string what, int got, int want);
		$display("tb_top: mismatch at %0t: %s got %h want %h", $time, what, got, want);
		err_cnt++;
	endtask

	// mostly short gaps, a few long ones, with occasional stretches of none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 60);
		end
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic bit esc_needed(logic [7:0] b);
		return b == pe_utf8_pkg::CH_SPACE || b == pe_utf8_pkg::CH_BSLASH ||
			b == pe_utf8_pkg::CH_STAR || b == pe_utf8_pkg::CH_QUEST ||
			b == pe_utf8_pkg::CH_PCT || (b == pe_utf8_pkg::CH_DOT && str_start) ||
			b < pe_utf8_pkg::CH_SPACE || b > pe_utf8_pkg::CH_TILDE;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
	endfunction

	task automatic put_escaped(logic [7:0] b);
		beat_bytes.push_back(pe_utf8_pkg::CH_PCT);
		beat_bytes.push_back(hex_char(b[7:4]));
		beat_bytes.push_back(hex_char(b[3:0]));
	endtask

	task automatic take_fresh(logic [7:0] b, logic eos);
		if (b[7:6] == 2'b11 && !eos) begin
			lead_wait = 1'b1;
			lead_byte = b;
		end else if (esc_needed(b)) begin
			put_escaped(b);
		end else begin
			beat_bytes.push_back(b);
		end
	endtask

	task automatic predict_beat(pe_utf8_pkg::in_t it);
		logic [7:0] b;
		logic eos;
		logic [7:0] lead;
		pe_utf8_pkg::out_t r;
		beat_bytes.delete();
		b = it.byte_in;
		eos = it.end_of_string;
		if (lead_wait) begin
			lead = lead_byte;
			lead_wait = 1'b0;
			lead_byte = '0;
			if (b[7]) begin
				beat_bytes.push_back(lead);
				beat_bytes.push_back(b);
				if (lead[7:4] == 4'hF) begin
					cont_left = 2'd2;
				end else if (lead[7:5] == 3'b111) begin
					cont_left = 2'd1;
				end else begin
					cont_left = 2'd0;
				end
			end else begin
				cont_left = 2'd0;
				put_escaped(lead);
				take_fresh(b, eos);
			end
		end else if (cont_left != 2'd0 && b[7]) begin
			beat_bytes.push_back(b);
			cont_left = cont_left - 2'd1;
		end else begin
			cont_left = 2'd0;
			take_fresh(b, eos);
		end
		str_start = 1'b0;
		if (eos) begin
			lead_wait = 1'b0;
			lead_byte = '0;
			cont_left = 2'd0;
			str_start = 1'b1;
		end
		foreach (beat_bytes[i]) begin
			r.byte_out = beat_bytes[i];
			r.last_out = (i == beat_bytes.size() - 1);
			r.string_done = r.last_out && eos;
			escaped_q.push_back(r);
		end
	endtask

	task automatic add_byte(logic [7:0] b, logic eos);
		pe_utf8_pkg::in_t it;
		it.byte_in = b;
		it.end_of_string = eos;
		raw_bytes_q.push_back(it);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			push_gap = 0;
			lead_wait = 1'b0;
			lead_byte = '0;
			cont_left = '0;
			str_start = 1'b1;
		end else begin
			if (push && !full) begin
				predict_beat(item);
				push_gap = pick_gap(push_calm);
			end else if (!push && push_gap > 0) begin
				push_gap--;
			end
			if (!(push && full)) begin
				if (push_gap == 0 && raw_bytes_q.size() > 0) begin
					item <= raw_bytes_q.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		pe_utf8_pkg::out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (escaped_q.size() == 0) begin
					report_mismatch("beat with nothing expected, byte_out", result.byte_out, 0);
				end else begin
					want = escaped_q.pop_front();
					if (result.byte_out !== want.byte_out) begin
						report_mismatch("byte_out", result.byte_out, want.byte_out);
					end
					if (result.last_out !== want.last_out) begin
						report_mismatch("last_out", result.last_out, want.last_out);
					end
					if (result.string_done !== want.string_done) begin
						report_mismatch("string_done", result.string_done, want.string_done);
					end
				end
				pop_gap = pick_gap(pop_calm);
			end else if (!pop && pop_gap > 0) begin
				pop_gap--;
			end
			pop <= (pop_gap == 0);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int n_rand;
		int len;
		int kind;
		int n_cont;
		logic [7:0] b;

		// escapes, edges of the byte range, lead at end of string
		add_byte(pe_utf8_pkg::CH_DOT, 1'b0);
		add_byte(pe_utf8_pkg::CH_DOT, 1'b0);
		add_byte(8'h41, 1'b0);
		add_byte(pe_utf8_pkg::CH_TILDE, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h1F, 1'b0);
		add_byte(pe_utf8_pkg::CH_SPACE, 1'b0);
		add_byte(pe_utf8_pkg::CH_BSLASH, 1'b0);
		add_byte(pe_utf8_pkg::CH_STAR, 1'b0);
		add_byte(pe_utf8_pkg::CH_QUEST, 1'b0);
		add_byte(pe_utf8_pkg::CH_PCT, 1'b0);
		add_byte(8'hFF, 1'b1);
		// utf-8 sequences, stray continuation, lone lead before an escaped byte
		add_byte(8'hC3, 1'b0);
		add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'hAC, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h9F, 1'b0);
		add_byte(8'h98, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hC5, 1'b0);
		add_byte(pe_utf8_pkg::CH_PCT, 1'b1);

		n_rand = 0;
		while (n_rand < RAND_BEATS) begin
			len = $urandom_range(1, 12);
			for (int p = 0; p < len; p++) begin
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					n_cont = $urandom_range(1, 3);
					if (n_cont == 1) begin
						b = {3'b110, 5'($urandom)};
					end else if (n_cont == 2) begin
						b = {4'b1110, 4'($urandom)};
					end else begin
						b = {4'b1111, 4'($urandom)};
					end
					// some sequences are cut short or run long
					if ($urandom_range(0, 9) == 0) begin
						n_cont = $urandom_range(0, 4);
					end
					add_byte(b, (p == len - 1) && n_cont == 0);
					n_rand++;
					for (int c = 0; c < n_cont; c++) begin
						add_byte({2'b10, 6'($urandom)}, (p == len - 1) && c == n_cont - 1);
						n_rand++;
					end
				end else begin
					if (kind < 80) begin
						b = 8'($urandom_range(32, 126));
					end else begin
						b = 8'($urandom);
					end
					add_byte(b, p == len - 1);
					n_rand++;
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (raw_bytes_q.size() > 0 || push || escaped_q.size() > 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (err_cnt == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
